>>> design/phin_pkg.sv
// Shared types, field widths and codes for the press-and-hold index navigator.
// No dependencies; every other design file imports this package.
`default_nettype none

package phin_pkg;

   localparam int MaxEntries  = 64;
   localparam int IndexBits   = 6;
   localparam int CountBits   = 7;
   localparam int TimeBits    = 32;
   localparam int MsBits      = 16;
   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = 16;

   localparam logic [CountBits-1:0] MaxCount = CountBits'(MaxEntries);

   // Opcodes of an input transaction.
   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   // Hold actions.
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_NEXT = 2'd1;
   localparam logic [1:0] ACT_PREV = 2'd2;
   localparam logic [1:0] ACT_JUMP = 2'd3;

   localparam logic [1:0] SRC_NONE = 2'd0;

   // Configuration register indexes.
   localparam logic [CsrIdxBits-1:0] CSR_ENTRY_COUNT    = 2'd0;
   localparam logic [CsrIdxBits-1:0] CSR_HOLD_THRESHOLD = 2'd1;
   localparam logic [CsrIdxBits-1:0] CSR_COOLDOWN       = 2'd2;

   localparam logic [MsBits-1:0] THRESHOLD_RESET = 16'd500;
   localparam logic [MsBits-1:0] COOLDOWN_RESET  = 16'd300;

   typedef logic [TimeBits-1:0] time_type;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [1:0]           hold_kind;
      logic [1:0]           press_source;
      logic [IndexBits-1:0] jump_index;
   } req_type;

   typedef struct packed {
      logic [IndexBits-1:0] current_index;
      logic                 load_now;
      logic [1:0]           held_kind;
      logic [MsBits-1:0]    hold_elapsed_ms;
   } rsp_type;

   // Control from the input stage to the core.
   typedef struct packed {
      logic    valid;
      logic    advance;
      req_type req;
   } stage_type;

endpackage

`default_nettype wire

>>> design/phin_in_stage.sv
// Input register of the navigator: holds one accepted transaction until the
// core can pass its result on. Depends on phin_pkg.
`default_nettype none

module phin_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire phin_pkg::req_type req_in,
   input  wire logic             out_free,
   output phin_pkg::stage_type   stage
);
   import phin_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   logic    advance;

   assign advance   = valid_ff && out_free;
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.advance = advance;
   assign stage.req     = req_ff;

endmodule

`default_nettype wire

>>> design/phin_core.sv
// Navigator state, configuration registers and the per-transaction update.
// Depends on phin_pkg.
`default_nettype none

module phin_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [phin_pkg::CsrIdxBits-1:0]  csr_index,
   input  wire logic [phin_pkg::CsrDataBits-1:0] csr_wdata,
   input  wire phin_pkg::stage_type              stage,
   output phin_pkg::rsp_type                     result
);
   import phin_pkg::*;

   logic [CountBits-1:0] entry_count_ff;
   logic [MsBits-1:0]    threshold_ff;
   logic [MsBits-1:0]    cooldown_ff;

   time_type             time_now_ff,     time_now_in;
   time_type             last_action_ff,  last_action_in;
   time_type             hold_start_ff,   hold_start_in;
   logic                 action_seen_ff,  action_seen_in;
   logic [1:0]           held_action_ff,  held_action_in;
   logic [1:0]           held_source_ff,  held_source_in;
   logic [IndexBits-1:0] held_target_ff,  held_target_in;
   logic [IndexBits-1:0] sel_ff,          sel_in;

   logic [CountBits-1:0] eff_count;
   logic                 has_entries;
   logic                 can_next;
   logic                 can_prev;
   logic                 can_jump_req;
   logic                 can_jump_held;
   time_type             time_tick;
   logic                 cooling;
   logic                 repeat_hold;
   logic                 kind_ok;
   logic                 fire;
   logic                 load;
   time_type             elapsed;
   req_type              req;

   assign req = stage.req;

   always_comb begin
      eff_count     = (entry_count_ff > MaxCount) ? MaxCount : entry_count_ff;
      has_entries   = (eff_count != '0);
      can_next      = has_entries && (({1'b0, sel_ff} + CountBits'(1)) < eff_count);
      can_prev      = has_entries && (sel_ff != '0);
      can_jump_req  = has_entries && ({1'b0, req.jump_index} < eff_count)
                      && (req.jump_index != sel_ff);
      can_jump_held = has_entries && ({1'b0, held_target_ff} < eff_count)
                      && (held_target_ff != sel_ff);
      time_tick     = time_now_ff + TimeBits'(1);
      // The cooldown distance wraps with the clock.
      cooling       = action_seen_ff
                      && ((time_now_ff - last_action_ff) < TimeBits'(cooldown_ff));
      repeat_hold   = (held_action_ff == req.hold_kind) && (held_source_ff == req.press_source)
                      && ((req.hold_kind != ACT_JUMP) || (held_target_ff == req.jump_index));
      fire          = (held_action_ff != ACT_NONE)
                      && ((time_tick - hold_start_ff) >= TimeBits'(threshold_ff));

      case (req.hold_kind)
         ACT_NEXT: kind_ok = can_next;
         ACT_PREV: kind_ok = can_prev;
         ACT_JUMP: kind_ok = can_jump_req;
         default:  kind_ok = 1'b0;
      endcase

      time_now_in    = time_now_ff;
      last_action_in = last_action_ff;
      hold_start_in  = hold_start_ff;
      action_seen_in = action_seen_ff;
      held_action_in = held_action_ff;
      held_source_in = held_source_ff;
      held_target_in = held_target_ff;
      sel_in         = sel_ff;
      load           = 1'b0;

      case (req.opcode)
         OP_PRESS: begin
            if (kind_ok && !cooling && !repeat_hold) begin
               held_action_in = req.hold_kind;
               held_source_in = req.press_source;
               held_target_in = (req.hold_kind == ACT_JUMP) ? req.jump_index : '0;
               hold_start_in  = time_now_ff;
            end
         end
         OP_RELEASE: begin
            if (held_source_ff == req.press_source) begin
               held_action_in = ACT_NONE;
               held_source_in = SRC_NONE;
               held_target_in = '0;
            end
         end
         OP_TICK: begin
            time_now_in = time_tick;
            if (fire) begin
               held_action_in = ACT_NONE;
               held_source_in = SRC_NONE;
               held_target_in = '0;
               last_action_in = time_tick;
               action_seen_in = 1'b1;
               case (held_action_ff)
                  ACT_NEXT: begin
                     if (can_next) begin
                        sel_in = sel_ff + IndexBits'(1);
                        load   = 1'b1;
                     end
                  end
                  ACT_PREV: begin
                     if (can_prev) begin
                        sel_in = sel_ff - IndexBits'(1);
                        load   = 1'b1;
                     end
                  end
                  ACT_JUMP: begin
                     if (can_jump_held) begin
                        sel_in = held_target_ff;
                        load   = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase

      elapsed = time_now_in - hold_start_in;
      result.current_index = sel_in;
      result.load_now      = load;
      result.held_kind     = held_action_in;
      if (held_action_in == ACT_NONE) begin
         result.hold_elapsed_ms = '0;
      end else if (elapsed > TimeBits'({MsBits{1'b1}})) begin
         result.hold_elapsed_ms = '1;
      end else begin
         result.hold_elapsed_ms = elapsed[MsBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         threshold_ff   <= THRESHOLD_RESET;
         cooldown_ff    <= COOLDOWN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENTRY_COUNT:    entry_count_ff <= csr_wdata[CountBits-1:0];
            CSR_HOLD_THRESHOLD: threshold_ff   <= csr_wdata[MsBits-1:0];
            CSR_COOLDOWN:       cooldown_ff    <= csr_wdata[MsBits-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff    <= '0;
         last_action_ff <= '0;
         hold_start_ff  <= '0;
         action_seen_ff <= 1'b0;
         held_action_ff <= ACT_NONE;
         held_source_ff <= SRC_NONE;
         held_target_ff <= '0;
         sel_ff         <= '0;
      end else if (stage.advance) begin
         time_now_ff    <= time_now_in;
         last_action_ff <= last_action_in;
         hold_start_ff  <= hold_start_in;
         action_seen_ff <= action_seen_in;
         held_action_ff <= held_action_in;
         held_source_ff <= held_source_in;
         held_target_ff <= held_target_in;
         sel_ff         <= sel_in;
      end
   end

endmodule

`default_nettype wire

>>> design/phin_out_stage.sv
// Result register of the navigator: keeps a finished result until the
// consumer takes it. Depends on phin_pkg.
`default_nettype none

module phin_out_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire phin_pkg::stage_type           stage,
   input  wire phin_pkg::rsp_type             result,
   output logic                               out_free,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [phin_pkg::IndexBits-1:0]     rsp_current_index,
   output logic                               rsp_load_now,
   output logic [1:0]                         rsp_held_kind,
   output logic [phin_pkg::MsBits-1:0]        rsp_hold_elapsed_ms
);
   import phin_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (stage.advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage.advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_current_index   = rsp_ff.current_index;
   assign rsp_load_now        = rsp_ff.load_now;
   assign rsp_held_kind       = rsp_ff.held_kind;
   assign rsp_hold_elapsed_ms = rsp_ff.hold_elapsed_ms;

endmodule

`default_nettype wire

>>> design/press_hold_index_navigator.sv
// Press-and-hold navigator over up to 64 entries. Each request transaction is a
// press, a release or a one millisecond tick, and gives exactly one response
// transaction with the selected index, a load strobe, the held action and the
// time held so far. The block takes one transaction per clock; an accepted
// transaction waits in the input register, then the whole update runs in one
// pass of logic into the result register. Throughput drops below one per clock
// only when rsp_ready stalls the result register. Configuration writes are
// taken at any time but must only be made while no transaction is in flight.
// Depends on phin_pkg, phin_in_stage, phin_core and phin_out_stage.
`default_nettype none

module press_hold_index_navigator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [1:0]                       req_hold_kind,
   input  wire logic [1:0]                       req_press_source,
   input  wire logic [phin_pkg::IndexBits-1:0]   req_jump_index,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [phin_pkg::IndexBits-1:0]        rsp_current_index,
   output logic                                  rsp_load_now,
   output logic [1:0]                            rsp_held_kind,
   output logic [phin_pkg::MsBits-1:0]           rsp_hold_elapsed_ms,
   input  wire logic                             csr_wr_en,
   input  wire logic [phin_pkg::CsrIdxBits-1:0]  csr_index,
   input  wire logic [phin_pkg::CsrDataBits-1:0] csr_wdata
);
   import phin_pkg::*;

   req_type   req_in;
   stage_type stage;
   rsp_type   result;
   logic      out_free;

   assign req_in.opcode       = req_opcode;
   assign req_in.hold_kind    = req_hold_kind;
   assign req_in.press_source = req_press_source;
   assign req_in.jump_index   = req_jump_index;

   phin_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_in    (req_in),
      .out_free  (out_free),
      .stage     (stage)
   );

   phin_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stage     (stage),
      .result    (result)
   );

   phin_out_stage u_out_stage (
      .clock               (clock),
      .reset               (reset),
      .stage               (stage),
      .result              (result),
      .out_free            (out_free),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_current_index   (rsp_current_index),
      .rsp_load_now        (rsp_load_now),
      .rsp_held_kind       (rsp_held_kind),
      .rsp_hold_elapsed_ms (rsp_hold_elapsed_ms)
   );

endmodule

`default_nettype wire

>>> design/phin_checker.sv
// Port-level checks for the navigator, attached to the top level by a bind.
// Depends on phin_pkg and press_hold_index_navigator.
`default_nettype none

module phin_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [phin_pkg::IndexBits-1:0]   rsp_current_index,
   input wire logic                             rsp_load_now,
   input wire logic [1:0]                       rsp_held_kind,
   input wire logic [phin_pkg::MsBits-1:0]      rsp_hold_elapsed_ms
);
   import phin_pkg::*;

   // A response that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_index)
         && $stable(rsp_load_now) && $stable(rsp_held_kind)
         && $stable(rsp_hold_elapsed_ms))
      else $error("response changed while stalled");

   // Reset empties both registers, so no response and room for a request.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // With nothing held, no hold time is reported.
   a_idle_elapsed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_held_kind == ACT_NONE) |-> rsp_hold_elapsed_ms == '0)
      else $error("hold time reported without a hold");

   // A move comes only from a fired hold, which is cleared on the same tick.
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_now |-> rsp_held_kind == ACT_NONE)
      else $error("load strobe while a hold remains");

endmodule

bind press_hold_index_navigator phin_checker u_phin_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_current_index   (rsp_current_index),
   .rsp_load_now        (rsp_load_now),
   .rsp_held_kind       (rsp_held_kind),
   .rsp_hold_elapsed_ms (rsp_hold_elapsed_ms)
);

`default_nettype wire
